// ----- rtl/etc_pkg.sv -----
`timescale 1ns / 1ps
// Shared widths, constants, types and tables for the epoch-seconds to calendar converter.
// Used by every module in rtl/; depends on nothing.
package etc_pkg;

   // Field widths of the transactions.
   localparam int EPOCH_W = 33;
   localparam int MICRO_W = 20;
   localparam int YEAR_W  = 12;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int HOUR_W  = 5;
   localparam int MIN_W   = 6;
   localparam int SEC_W   = 6;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 64;

   // Pipeline depth, input register through result register.
   localparam int NUM_STAGES = 10;

   // Internal value widths.
   localparam int U_W    = 34;  // biased seconds, always non-negative
   localparam int DAYS_W = 17;  // biased day count
   localparam int SOD_W  = 17;  // second of day
   localparam int Z_W    = 20;  // day number counted from 0000-03-01
   localparam int DOE_W  = 18;  // day of 400-year era
   localparam int MOD_W  = 11;  // minute of day
   localparam int YOE_W  = 9;   // year of era
   localparam int DOY_W  = 9;   // day of March-based year
   localparam int MP_W   = 4;   // March-based month index

   // Time constants.
   localparam longint unsigned SECS_PER_DAY = 64'd86400;
   localparam longint unsigned DAY_BIAS     = 64'd49711;
   localparam longint unsigned SEC_BIAS     = DAY_BIAS * SECS_PER_DAY;
   localparam longint unsigned DAYS_PER_ERA = 64'd146097;
   localparam longint unsigned Z_OFFSET     = 64'd719468 - DAY_BIAS;
   localparam longint unsigned ERA4_START   = 64'd4 * DAYS_PER_ERA;
   localparam longint unsigned ERA5_START   = 64'd5 * DAYS_PER_ERA;
   localparam longint unsigned LAST_DOE     = DAYS_PER_ERA - 64'd1;
   localparam logic [YEAR_W-1:0] ERA4_YEAR  = 12'd1600;
   localparam logic [YEAR_W-1:0] ERA5_YEAR  = 12'd2000;

   // Reciprocal multipliers: q = (x * MUL) >> SHIFT is exact over the whole input range
   // because SHIFT covers the bit width of x plus the bit width of the divisor.
   localparam int DAYQ_SHIFT = 37;  // (u >> 7) / 675, i.e. u / 86400
   localparam int DAYQ_MUL_W = 28;
   localparam logic [DAYQ_MUL_W-1:0] DAYQ_MUL =
      DAYQ_MUL_W'((64'd1 << DAYQ_SHIFT) / 64'd675 + 64'd1);

   localparam int MOD_SHIFT = 23;   // sod / 60
   localparam int MOD_MUL_W = 18;
   localparam logic [MOD_MUL_W-1:0] MOD_MUL =
      MOD_MUL_W'((64'd1 << MOD_SHIFT) / 64'd60 + 64'd1);

   localparam int HOUR_SHIFT = 29;  // sod / 3600
   localparam int HOUR_MUL_W = 18;
   localparam logic [HOUR_MUL_W-1:0] HOUR_MUL =
      HOUR_MUL_W'((64'd1 << HOUR_SHIFT) / 64'd3600 + 64'd1);

   localparam int D1_SHIFT = 29;    // doe / 1460
   localparam int D1_MUL_W = 19;
   localparam logic [D1_MUL_W-1:0] D1_MUL =
      D1_MUL_W'((64'd1 << D1_SHIFT) / 64'd1460 + 64'd1);

   localparam int D2_SHIFT = 34;    // doe / 36524
   localparam int D2_MUL_W = 19;
   localparam logic [D2_MUL_W-1:0] D2_MUL =
      D2_MUL_W'((64'd1 << D2_SHIFT) / 64'd36524 + 64'd1);

   localparam int YOE_SHIFT = 27;   // yn / 365
   localparam int YOE_MUL_W = 19;
   localparam logic [YOE_MUL_W-1:0] YOE_MUL =
      YOE_MUL_W'((64'd1 << YOE_SHIFT) / 64'd365 + 64'd1);

   localparam int MP_SHIFT = 19;    // (5 * doy + 2) / 153
   localparam int MP_MUL_W = 12;
   localparam logic [MP_MUL_W-1:0] MP_MUL =
      MP_MUL_W'((64'd1 << MP_SHIFT) / 64'd153 + 64'd1);

   // Time of day travelling between modules.
   typedef struct packed {
      logic [HOUR_W-1:0] hour;
      logic [MIN_W-1:0]  minute;
      logic [SEC_W-1:0]  second;
   } hms_type;

   // Calendar date travelling between modules.
   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
   } ymd_type;

   // First day of each March-based month within its year.
   function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
      logic [DOY_W-1:0] ms;
      case (mp)
         4'd0:    ms = 9'd0;
         4'd1:    ms = 9'd31;
         4'd2:    ms = 9'd61;
         4'd3:    ms = 9'd92;
         4'd4:    ms = 9'd122;
         4'd5:    ms = 9'd153;
         4'd6:    ms = 9'd184;
         4'd7:    ms = 9'd214;
         4'd8:    ms = 9'd245;
         4'd9:    ms = 9'd275;
         4'd10:   ms = 9'd306;
         4'd11:   ms = 9'd337;
         default: ms = 9'd0;
      endcase
      return ms;
   endfunction

endpackage

// ----- rtl/epoch_seconds_to_calendar.sv -----
`timescale 1ns / 1ps
// Epoch seconds to UTC calendar date and time of day, ten register stages deep.
// Throughput: one transaction per cycle unless rsp_tready stalls the output; stages
// advance independently, so bubbles close up and a new transaction is taken while a
// finished result waits on rsp_tready, as long as an earlier stage is empty.
// Depth is set by the chain of constant divisions, done by reciprocal multiplies.
// Reset clears the stage valid bits only. Depends on etc_pkg and the etc_ modules.
module epoch_seconds_to_calendar (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [32:0] epoch_seconds, [52:33] micro_in, [55:53] zero
   input  logic [etc_pkg::REQ_DATA_W-1:0]       req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [11:0] year, [15:12] month, [20:16] day_of_month, [25:21] hour,
   // [31:26] minute, [37:32] second, [57:38] micro_out, [63:58] zero
   output logic [etc_pkg::RSP_DATA_W-1:0]       rsp_tdata
);

   localparam int LAST = etc_pkg::NUM_STAGES - 1;
   localparam int PAD_W = etc_pkg::RSP_DATA_W - etc_pkg::YEAR_W - etc_pkg::MONTH_W
                          - etc_pkg::DAY_W - etc_pkg::HOUR_W - etc_pkg::MIN_W
                          - etc_pkg::SEC_W - etc_pkg::MICRO_W;

   logic [etc_pkg::NUM_STAGES-1:0]     valid_ff, valid_in;
   logic [etc_pkg::NUM_STAGES-1:0]     load;
   logic [etc_pkg::EPOCH_W-1:0]        epoch;
   logic [etc_pkg::U_W-1:0]            u_in, u_ff;
   logic [etc_pkg::MICRO_W-1:0]        micro_ff [LAST];
   logic [etc_pkg::MICRO_W-1:0]        micro_out_ff;
   logic [etc_pkg::SOD_W-1:0]          sod;
   logic [etc_pkg::DOE_W-1:0]          doe;
   logic                               era5;
   etc_pkg::hms_type                   hms;
   etc_pkg::ymd_type                   ymd;
   etc_pkg::hms_type                   hms_out_ff;
   etc_pkg::ymd_type                   ymd_out_ff;

   // Stage enables: a stage loads when it is empty or its content moves on.
   always_comb begin
      load[LAST] = !valid_ff[LAST] || rsp_tready;
      for (int i = LAST - 1; i >= 0; i--) begin
         load[i] = !valid_ff[i] || load[i+1];
      end
      valid_in[0] = load[0] ? req_tvalid : valid_ff[0];
      for (int i = 1; i <= LAST; i++) begin
         valid_in[i] = load[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   assign req_tready = load[0];
   assign rsp_tvalid = valid_ff[LAST];

   // Bias the signed seconds so the day split works on a non-negative value.
   always_comb begin
      epoch = req_tdata[etc_pkg::EPOCH_W-1:0];
      u_in  = {epoch[etc_pkg::EPOCH_W-1], epoch} + etc_pkg::U_W'(etc_pkg::SEC_BIAS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Input register, microsecond delay line and result register.
   always_ff @(posedge clock) begin
      if (load[0]) begin
         u_ff        <= u_in;
         micro_ff[0] <= req_tdata[etc_pkg::EPOCH_W +: etc_pkg::MICRO_W];
      end
      for (int i = 1; i < LAST; i++) begin
         if (load[i]) begin
            micro_ff[i] <= micro_ff[i-1];
         end
      end
      if (load[LAST]) begin
         micro_out_ff <= micro_ff[LAST-1];
         hms_out_ff   <= hms;
         ymd_out_ff   <= ymd;
      end
   end

   etc_day_split u_day_split (
      .clock (clock),
      .load  (load[2:1]),
      .u     (u_ff),
      .sod   (sod),
      .doe   (doe),
      .era5  (era5)
   );

   etc_time_of_day u_time_of_day (
      .clock (clock),
      .load  (load[8:3]),
      .sod   (sod),
      .hms   (hms)
   );

   etc_civil_date u_civil_date (
      .clock (clock),
      .load  (load[8:3]),
      .doe   (doe),
      .era5  (era5),
      .ymd   (ymd)
   );

   assign rsp_tdata = {PAD_W'(0), micro_out_ff, hms_out_ff.second, hms_out_ff.minute,
                       hms_out_ff.hour, ymd_out_ff.day, ymd_out_ff.month, ymd_out_ff.year};

endmodule

// ----- rtl/etc_day_split.sv -----
`timescale 1ns / 1ps
// Splits biased epoch seconds into a second of day and a day of the 400-year era.
// Depends on etc_pkg.
module etc_day_split (
   input  logic                        clock,
   input  logic [1:0]                  load,        // stage enables, lowest first
   input  logic [etc_pkg::U_W-1:0]     u,           // seconds plus bias, non-negative
   output logic [etc_pkg::SOD_W-1:0]   sod,
   output logic [etc_pkg::DOE_W-1:0]   doe,
   output logic                        era5
);

   localparam int X_W = etc_pkg::U_W - 7;
   localparam int P_W = X_W + etc_pkg::DAYQ_MUL_W;

   logic [P_W-1:0]                   dayq_prod;
   logic [etc_pkg::DAYS_W-1:0]       days_in, days_ff;
   logic [etc_pkg::SOD_W-1:0]        ulo_in, ulo_ff;
   logic [etc_pkg::U_W-1:0]          day_secs;
   logic [etc_pkg::Z_W-1:0]          z;
   logic                             era5_in, era5_ff;
   logic [etc_pkg::SOD_W-1:0]        sod_in, sod_ff;
   logic [etc_pkg::DOE_W-1:0]        doe_in, doe_ff;

   // Day count: divide by 86400 as a shift by 7 and a reciprocal multiply for 675.
   always_comb begin
      dayq_prod = P_W'(u[etc_pkg::U_W-1:7]) * P_W'(etc_pkg::DAYQ_MUL);
      days_in   = dayq_prod[etc_pkg::DAYQ_SHIFT +: etc_pkg::DAYS_W];
      ulo_in    = u[etc_pkg::SOD_W-1:0];
   end

   // Second of day from the low bits; era and day of era from the day number.
   always_comb begin
      day_secs = etc_pkg::U_W'(days_ff) * etc_pkg::U_W'(etc_pkg::SECS_PER_DAY);
      sod_in   = ulo_ff - day_secs[etc_pkg::SOD_W-1:0];
      z        = etc_pkg::Z_W'(days_ff) + etc_pkg::Z_W'(etc_pkg::Z_OFFSET);
      era5_in  = (z >= etc_pkg::Z_W'(etc_pkg::ERA5_START));
      if (era5_in) begin
         doe_in = etc_pkg::DOE_W'(z - etc_pkg::Z_W'(etc_pkg::ERA5_START));
      end else begin
         doe_in = etc_pkg::DOE_W'(z - etc_pkg::Z_W'(etc_pkg::ERA4_START));
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         days_ff <= days_in;
         ulo_ff  <= ulo_in;
      end
      if (load[1]) begin
         sod_ff  <= sod_in;
         doe_ff  <= doe_in;
         era5_ff <= era5_in;
      end
   end

   assign sod  = sod_ff;
   assign doe  = doe_ff;
   assign era5 = era5_ff;

endmodule

// ----- rtl/etc_time_of_day.sv -----
`timescale 1ns / 1ps
// Turns a second of day into hour, minute and second, then delays them to the date path.
// Depends on etc_pkg.
module etc_time_of_day (
   input  logic                        clock,
   input  logic [5:0]                  load,        // stage enables, lowest first
   input  logic [etc_pkg::SOD_W-1:0]   sod,
   output etc_pkg::hms_type            hms
);

   localparam int MP_PW = etc_pkg::SOD_W + etc_pkg::MOD_MUL_W;
   localparam int HP_PW = etc_pkg::SOD_W + etc_pkg::HOUR_MUL_W;
   localparam int DELAY = 4;

   logic [MP_PW-1:0]                 mod_prod;
   logic [HP_PW-1:0]                 hour_prod;
   logic [etc_pkg::MOD_W-1:0]        mod_in, mod_ff;
   logic [etc_pkg::HOUR_W-1:0]       hour_in, hour_ff;
   logic [etc_pkg::SOD_W-1:0]        sod_ff;
   logic [etc_pkg::SOD_W-1:0]        sec_full;
   logic [etc_pkg::MOD_W-1:0]        min_full;
   etc_pkg::hms_type                 hms_in;
   etc_pkg::hms_type                 hms_ff [DELAY+1];

   // Minute of day and hour, both by reciprocal multiply.
   always_comb begin
      mod_prod  = MP_PW'(sod) * MP_PW'(etc_pkg::MOD_MUL);
      hour_prod = HP_PW'(sod) * HP_PW'(etc_pkg::HOUR_MUL);
      mod_in    = mod_prod[etc_pkg::MOD_SHIFT +: etc_pkg::MOD_W];
      hour_in   = hour_prod[etc_pkg::HOUR_SHIFT +: etc_pkg::HOUR_W];
   end

   // Remainders give second of minute and minute of hour.
   always_comb begin
      sec_full      = sod_ff - etc_pkg::SOD_W'(mod_ff) * etc_pkg::SOD_W'(60);
      min_full      = mod_ff - etc_pkg::MOD_W'(hour_ff) * etc_pkg::MOD_W'(60);
      hms_in.hour   = hour_ff;
      hms_in.minute = min_full[etc_pkg::MIN_W-1:0];
      hms_in.second = sec_full[etc_pkg::SEC_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         mod_ff  <= mod_in;
         hour_ff <= hour_in;
         sod_ff  <= sod;
      end
      if (load[1]) begin
         hms_ff[0] <= hms_in;
      end
      // Delay line that keeps the time aligned with the date path.
      for (int i = 1; i <= DELAY; i++) begin
         if (load[i+1]) begin
            hms_ff[i] <= hms_ff[i-1];
         end
      end
   end

   assign hms = hms_ff[DELAY];

endmodule

// ----- rtl/etc_civil_date.sv -----
`timescale 1ns / 1ps
// Converts a day of the 400-year era into Gregorian year, month and day of month.
// Depends on etc_pkg.
module etc_civil_date (
   input  logic                        clock,
   input  logic [5:0]                  load,        // stage enables, lowest first
   input  logic [etc_pkg::DOE_W-1:0]   doe,
   input  logic                        era5,
   output etc_pkg::ymd_type            ymd
);

   localparam int D1_PW  = etc_pkg::DOE_W + etc_pkg::D1_MUL_W;
   localparam int D2_PW  = etc_pkg::DOE_W + etc_pkg::D2_MUL_W;
   localparam int YOE_PW = etc_pkg::DOE_W + etc_pkg::YOE_MUL_W;
   localparam int MPX_W  = 11;
   localparam int MP_PW  = MPX_W + etc_pkg::MP_MUL_W;
   localparam int D1_W   = 7;
   localparam int D2_W   = 3;

   // Stage one: leap-day corrections.
   logic [D1_PW-1:0]                 d1_prod;
   logic [D2_PW-1:0]                 d2_prod;
   logic [D1_W-1:0]                  d1_ff;
   logic [D2_W-1:0]                  d2_ff;
   logic                             d3_ff;
   logic [etc_pkg::DOE_W-1:0]        doe1_ff;
   logic                             era1_ff;
   // Stage two: corrected day count.
   logic [etc_pkg::DOE_W-1:0]        yn_in, yn_ff;
   logic [etc_pkg::DOE_W-1:0]        doe2_ff;
   logic                             era2_ff;
   // Stage three: year of era.
   logic [YOE_PW-1:0]                yoe_prod;
   logic [etc_pkg::YOE_W-1:0]        yoe3_ff;
   logic [etc_pkg::DOE_W-1:0]        doe3_ff;
   logic                             era3_ff;
   // Stage four: day of year.
   logic [etc_pkg::YOE_W-1:0]        c100;
   logic [etc_pkg::DOE_W-1:0]        yday_base;
   logic [etc_pkg::DOE_W-1:0]        doy_full;
   logic [etc_pkg::DOY_W-1:0]        doy4_ff;
   logic [etc_pkg::YOE_W-1:0]        yoe4_ff;
   logic                             era4_ff;
   // Stage five: month index.
   logic [MPX_W-1:0]                 mp_x;
   logic [MP_PW-1:0]                 mp_prod;
   logic [etc_pkg::MP_W-1:0]         mp5_ff;
   logic [etc_pkg::DOY_W-1:0]        doy5_ff;
   logic [etc_pkg::YOE_W-1:0]        yoe5_ff;
   logic                             era5_ff;
   // Stage six: final date.
   logic [etc_pkg::DOY_W-1:0]        day_full;
   logic                             jan_feb;
   etc_pkg::ymd_type                 ymd_in, ymd_ff;

   // Leap-day counts within the era: every 4 years, every 100, and the last day.
   always_comb begin
      d1_prod = D1_PW'(doe) * D1_PW'(etc_pkg::D1_MUL);
      d2_prod = D2_PW'(doe) * D2_PW'(etc_pkg::D2_MUL);
   end

   // Day count with leap days taken out, a multiple of 365 per year.
   assign yn_in = doe1_ff - etc_pkg::DOE_W'(d1_ff) + etc_pkg::DOE_W'(d2_ff)
                  - etc_pkg::DOE_W'(d3_ff);

   assign yoe_prod = YOE_PW'(yn_ff) * YOE_PW'(etc_pkg::YOE_MUL);

   // Day of year: subtract the days in the whole years before it.
   always_comb begin
      c100      = etc_pkg::YOE_W'(yoe3_ff >= 9'd100) + etc_pkg::YOE_W'(yoe3_ff >= 9'd200)
                  + etc_pkg::YOE_W'(yoe3_ff >= 9'd300);
      yday_base = etc_pkg::DOE_W'(yoe3_ff) * etc_pkg::DOE_W'(365)
                  + etc_pkg::DOE_W'(yoe3_ff >> 2) - etc_pkg::DOE_W'(c100);
      doy_full  = doe3_ff - yday_base;
   end

   // March-based month index.
   always_comb begin
      mp_x    = MPX_W'(doy4_ff) * MPX_W'(5) + MPX_W'(2);
      mp_prod = MP_PW'(mp_x) * MP_PW'(etc_pkg::MP_MUL);
   end

   // Month, day and year; January and February belong to the next civil year.
   always_comb begin
      jan_feb      = (mp5_ff >= 4'd10);
      day_full     = doy5_ff - etc_pkg::month_start(mp5_ff) + 9'd1;
      ymd_in.day   = day_full[etc_pkg::DAY_W-1:0];
      if (jan_feb) begin
         ymd_in.month = mp5_ff - 4'd9;
      end else begin
         ymd_in.month = mp5_ff + 4'd3;
      end
      ymd_in.year  = etc_pkg::YEAR_W'(yoe5_ff) + (era5_ff ? etc_pkg::ERA5_YEAR :
                     etc_pkg::ERA4_YEAR) + etc_pkg::YEAR_W'(jan_feb);
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         d1_ff   <= d1_prod[etc_pkg::D1_SHIFT +: D1_W];
         d2_ff   <= d2_prod[etc_pkg::D2_SHIFT +: D2_W];
         d3_ff   <= (doe == etc_pkg::DOE_W'(etc_pkg::LAST_DOE));
         doe1_ff <= doe;
         era1_ff <= era5;
      end
      if (load[1]) begin
         yn_ff   <= yn_in;
         doe2_ff <= doe1_ff;
         era2_ff <= era1_ff;
      end
      if (load[2]) begin
         yoe3_ff <= yoe_prod[etc_pkg::YOE_SHIFT +: etc_pkg::YOE_W];
         doe3_ff <= doe2_ff;
         era3_ff <= era2_ff;
      end
      if (load[3]) begin
         doy4_ff <= doy_full[etc_pkg::DOY_W-1:0];
         yoe4_ff <= yoe3_ff;
         era4_ff <= era3_ff;
      end
      if (load[4]) begin
         mp5_ff  <= mp_prod[etc_pkg::MP_SHIFT +: etc_pkg::MP_W];
         doy5_ff <= doy4_ff;
         yoe5_ff <= yoe4_ff;
         era5_ff <= era4_ff;
      end
      if (load[5]) begin
         ymd_ff  <= ymd_in;
      end
   end

   assign ymd = ymd_ff;

endmodule

// ----- test/epoch_seconds_to_calendar_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for epoch_seconds_to_calendar: random and directed timestamps with
// random stalls on both streams, every result checked against a calendar predictor.
// Depends on etc_pkg and the RTL under rtl/.
module epoch_seconds_to_calendar_test;

   localparam int IDLE_LIMIT   = 1000;
   localparam int RANDOM_ITEMS = 1600;
   localparam int DRAIN_CYCLES = 20;
   localparam longint SPAN_DAYS = 49710;

   // One timestamp waiting to be sent.
   typedef struct packed {
      logic [etc_pkg::EPOCH_W-1:0] epoch;
      logic [etc_pkg::MICRO_W-1:0] micro;
   } stamp_type;

   // One calendar result as the block should produce it.
   typedef struct packed {
      logic [etc_pkg::YEAR_W-1:0]  year;
      logic [etc_pkg::MONTH_W-1:0] month;
      logic [etc_pkg::DAY_W-1:0]   day;
      logic [etc_pkg::HOUR_W-1:0]  hour;
      logic [etc_pkg::MIN_W-1:0]   minute;
      logic [etc_pkg::SEC_W-1:0]   second;
      logic [etc_pkg::MICRO_W-1:0] micro;
   } calendar_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // [32:0] epoch_seconds, [52:33] micro_in, [55:53] zero
   logic [etc_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // [11:0] year, [15:12] month, [20:16] day_of_month, [25:21] hour,
   // [31:26] minute, [37:32] second, [57:38] micro_out, [63:58] zero
   logic [etc_pkg::RSP_DATA_W-1:0] rsp_tdata;

   stamp_type    pending_stamps[$];
   calendar_type expected_dates[$];
   int mismatches = 0;
   int idle_cycles = 0;
   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;
   int req_hold = 0;
   int rsp_hold = 0;
   int req_burst = 0;
   int rsp_burst = 0;

   epoch_seconds_to_calendar dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Floor division, so negative times land on the earlier day.
   function automatic longint floor_quot(input longint a, input longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && ((a < 0) != (b < 0)))
         q = q - 1;
      return q;
   endfunction

   // Converts a timestamp to the Gregorian date and time of day it names.
   function automatic calendar_type to_calendar(input stamp_type s);
      longint secs, days, sod, z, era, doe, yoe, doy, mp, yr, mon;
      calendar_type c;
      secs = $signed(s.epoch);
      days = floor_quot(secs, 86400);
      sod  = secs - days * 86400;
      // Day count to year, month and day, years counted from March 1.
      z    = days + 719468;
      era  = floor_quot(z, 146097);
      doe  = z - era * 146097;
      yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp   = (5 * doy + 2) / 153;
      yr   = yoe + era * 400;
      mon  = (mp < 10) ? mp + 3 : mp - 9;
      if (mon <= 2)
         yr = yr + 1;
      c.year   = etc_pkg::YEAR_W'(yr);
      c.month  = etc_pkg::MONTH_W'(mon);
      c.day    = etc_pkg::DAY_W'(doy - (153 * mp + 2) / 5 + 1);
      c.hour   = etc_pkg::HOUR_W'(sod / 3600);
      c.minute = etc_pkg::MIN_W'((sod / 60) % 60);
      c.second = etc_pkg::SEC_W'(sod % 60);
      c.micro  = s.micro;
      return c;
   endfunction

   // Wait before the next transaction on one side; long zero-wait bursts now and then.
   function automatic int draw_wait(inout int burst_left);
      if (burst_left > 0) begin
         burst_left = burst_left - 1;
         return 0;
      end
      if ($urandom_range(0, 7) == 0) begin
         burst_left = $urandom_range(20, 60);
         return 0;
      end
      return $urandom_range(0, 17);
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Request driver: holds a transaction until it is taken, then waits a drawn gap.
   always @(negedge clock) begin
      stamp_type s;
      if (!reset) begin
         if (!req_tvalid || req_taken) begin
            if (req_hold > 0) begin
               req_tvalid <= 1'b0;
               req_hold = req_hold - 1;
            end else if (pending_stamps.size() > 0) begin
               s = pending_stamps.pop_front();
               req_tdata  <= {3'b000, s.micro, s.epoch};
               req_tvalid <= 1'b1;
               req_hold = draw_wait(req_burst);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response back-pressure: after each result, ready drops for a drawn wait, which can be zero.
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_taken)
            rsp_hold = draw_wait(rsp_burst);
         if (rsp_hold > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold = rsp_hold - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Monitor: predicts on each accepted request and checks each accepted response.
   always @(posedge clock) begin
      stamp_type s;
      calendar_type want;
      if (!reset) begin
         req_taken <= req_tvalid && req_tready;
         rsp_taken <= rsp_tvalid && rsp_tready;
         if (req_tvalid && req_tready) begin
            s.epoch = req_tdata[32:0];
            s.micro = req_tdata[52:33];
            expected_dates.push_back(to_calendar(s));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_dates.size() == 0) begin
               $display("%0t: unexpected result, got %h", $time, rsp_tdata);
               mismatches++;
            end else begin
               want = expected_dates.pop_front();
               check_field("year", want.year, rsp_tdata[11:0]);
               check_field("month", want.month, rsp_tdata[15:12]);
               check_field("day_of_month", want.day, rsp_tdata[20:16]);
               check_field("hour", want.hour, rsp_tdata[25:21]);
               check_field("minute", want.minute, rsp_tdata[31:26]);
               check_field("second", want.second, rsp_tdata[37:32]);
               check_field("micro_out", want.micro, rsp_tdata[57:38]);
               check_field("padding", 0, rsp_tdata[63:58]);
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   // Watchdog on cycles without any transaction.
   initial begin
      while (idle_cycles < IDLE_LIMIT)
         @(posedge clock);
      $display("Mismatches found");
      $finish;
   end

   // Stimulus and end of run.
   initial begin
      longint directed[$];
      longint d, t;
      stamp_type s;
      int mode;

      // Extremes, midnight crossings, year ends, leap days and the 32-bit rollover.
      directed = '{-64'sd4294967296, 64'sd4294967295, 0, -1, 1, 86399, 86400,
                   -86400, -86401, 946684799, 946684800, 951782400, 951868799,
                   951868800, 64'sd4107455999, 64'sd4107456000, -64'sd2203977601,
                   -64'sd2203891200, 64'sd2147483647, 64'sd2147483648, -64'sd2147483648,
                   -64'sd2147483649, 64'sd4291718399};
      foreach (directed[i]) begin
         s.epoch = etc_pkg::EPOCH_W'(directed[i]);
         case (i % 4)
            0: s.micro = '0;
            1: s.micro = 20'd999999;
            2: s.micro = 20'd1000000;
            default: s.micro = '1;
         endcase
         pending_stamps.push_back(s);
      end

      // Random timestamps: half fully random, half near midnight, on day boundaries or at a random second of a day.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         mode = $urandom_range(0, 3);
         d = $urandom_range(0, 2 * SPAN_DAYS - 1);
         d = d - SPAN_DAYS;
         case (mode)
            0, 1: s.epoch = {1'($urandom_range(0, 1)), 32'($urandom())};
            2: begin
               t = d * 86400 - 1 + $urandom_range(0, 2);
               s.epoch = etc_pkg::EPOCH_W'(t);
            end
            default: begin
               case ($urandom_range(0, 2))
                  0: t = d * 86400;
                  1: t = d * 86400 + 86399;
                  default: t = d * 86400 + $urandom_range(0, 86399);
               endcase
               s.epoch = etc_pkg::EPOCH_W'(t);
            end
         endcase
         if ($urandom_range(0, 4) == 0)
            s.micro = 20'($urandom());
         else
            s.micro = 20'($urandom_range(0, 999999));
         pending_stamps.push_back(s);
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_stamps.size() != 0 || req_tvalid)
         @(posedge clock);
      while (expected_dates.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/etc_pkg.sv
rtl/etc_day_split.sv
rtl/etc_time_of_day.sv
rtl/etc_civil_date.sv
rtl/epoch_seconds_to_calendar.sv
test/epoch_seconds_to_calendar_test.sv
